// ===== hw/rtl/cfp_pkg.sv =====
// cfp_pkg: shared types and constants of the CRC-checked frame parser.
// No dependencies.
package cfp_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned CntW        = 7;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned MaxPayloadDef = 64;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
  localparam logic [ByteW-1:0] ProtoVerRst   = 8'h01;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_PROTO_VER   = 2'd2,
    REG_NONE        = 2'd3
  } cfg_reg_e;

  // Parser phase of the front end.
  typedef enum logic [1:0] {
    PH_SYNC1 = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_HDR   = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] proto_version;
  } cfg_t;

  // One checked frame waiting for output.
  typedef struct packed {
    logic [ByteW-1:0] seq;
    logic [ByteW-1:0] kind;
    logic [CntW-1:0]  len;
    logic             bank;
  } desc_t;

endpackage

// ===== hw/rtl/cfp_in_if.sv =====
// cfp_in_if: receive byte channel (valid/ready).
// Depends on cfp_pkg.
interface cfp_in_if;
  logic                     valid;
  logic                     ready;
  logic [cfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cfp_out_if.sv =====
// cfp_out_if: result channel, one payload byte per transfer (valid/ready).
// Depends on cfp_pkg.
interface cfp_out_if;
  logic                      valid;
  logic                      ready;
  logic [cfp_pkg::ByteW-1:0] seq_num;
  logic [cfp_pkg::ByteW-1:0] frame_kind;
  logic [cfp_pkg::CntW-1:0]  payload_count;
  logic                      has_data;
  logic [cfp_pkg::ByteW-1:0] data_byte;
  logic [cfp_pkg::IdxW-1:0]  byte_index;
  logic                      last;

  modport source (output valid, output seq_num, output frame_kind, output payload_count,
                  output has_data, output data_byte, output byte_index, output last,
                  input ready);
  modport sink   (input valid, input seq_num, input frame_kind, input payload_count,
                  input has_data, input data_byte, input byte_index, input last,
                  output ready);
endinterface

// ===== hw/rtl/cfp_front.sv =====
// cfp_front: sync hunt, header parse, running CRC-16/MODBUS and payload write.
// Depends on cfp_pkg, cfp_in_if.
module cfp_front #(
  parameter int unsigned MAX_PAYLOAD = cfp_pkg::MaxPayloadDef,
  parameter int unsigned MEM_IDX_W   = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfp_pkg::cfg_t        cfg_i,
  cfp_in_if.sink               rx_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cfp_pkg::desc_t       desc_o,
  output logic                 wr_en_o,
  output logic                 wr_bank_o,
  output logic [MEM_IDX_W-1:0] wr_addr_o,
  output logic [cfp_pkg::ByteW-1:0] wr_data_o
);
  import cfp_pkg::*;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] seq_q, seq_d;
  logic [ByteW-1:0] kind_q, kind_d;
  logic [ByteW-1:0] len_low_q, len_low_d;
  logic [CntW-1:0]  exp_len_q, exp_len_d;
  logic [15:0]      crc_q, crc_d;
  logic [ByteW-1:0] crc_low_q, crc_low_d;
  logic             ver_bad_q, ver_bad_d;
  logic             bank_q, bank_d;

  logic             acc;
  logic [ByteW-1:0] b;
  logic [15:0]      crc_next;
  logic [15:0]      len16;

  assign rx_i.ready = !q_full_i;
  assign acc        = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign crc_next   = crc16_step(crc_q, b);
  assign len16      = {b, len_low_q};

  assign desc_o    = '{seq: seq_q, kind: kind_q, len: exp_len_q, bank: bank_q};
  assign wr_bank_o = bank_q;
  assign wr_addr_o = pos_q[MEM_IDX_W-1:0];
  assign wr_data_o = b;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    seq_d     = seq_q;
    kind_d    = kind_q;
    len_low_d = len_low_q;
    exp_len_d = exp_len_q;
    crc_d     = crc_q;
    crc_low_d = crc_low_q;
    ver_bad_d = ver_bad_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    wr_en_o   = 1'b0;
    if (acc) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (b == cfg_i.sync_first) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == cfg_i.sync_second) begin
            phase_d   = PH_HDR;
            pos_d     = '0;
            crc_d     = CrcInit;
            ver_bad_d = 1'b0;
          end else if (b != cfg_i.sync_first) begin
            phase_d   = PH_SYNC1;
            pos_d     = '0;
            exp_len_d = '0;
            crc_d     = CrcInit;
            ver_bad_d = 1'b0;
          end
        end
        PH_HDR: begin
          crc_d = crc_next;
          pos_d = pos_q + 1'b1;
          case (pos_q)
            7'd0: ver_bad_d = (b != cfg_i.proto_version);
            7'd1: seq_d     = b;
            7'd2: kind_d    = b;
            7'd3: len_low_d = b;
            default: begin
              if (ver_bad_q || (len16 > 16'(MAX_PAYLOAD))) begin
                phase_d   = PH_SYNC1;
                exp_len_d = '0;
                crc_d     = CrcInit;
                ver_bad_d = 1'b0;
              end else begin
                phase_d   = PH_BODY;
                exp_len_d = len16[CntW-1:0];
              end
              pos_d = '0;
            end
          endcase
        end
        PH_BODY: begin
          if (pos_q < exp_len_q) begin
            wr_en_o = 1'b1;
            crc_d   = crc_next;
            pos_d   = pos_q + 1'b1;
          end else if (pos_q == exp_len_q) begin
            crc_low_d = b;
            pos_d     = pos_q + 1'b1;
          end else begin
            if ({b, crc_low_q} == crc_q) begin
              push_o = 1'b1;
              bank_d = !bank_q;
            end
            phase_d   = PH_SYNC1;
            pos_d     = '0;
            exp_len_d = '0;
            crc_d     = CrcInit;
            ver_bad_d = 1'b0;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      pos_q     <= '0;
      seq_q     <= '0;
      kind_q    <= '0;
      len_low_q <= '0;
      exp_len_q <= '0;
      crc_q     <= CrcInit;
      crc_low_q <= '0;
      ver_bad_q <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      seq_q     <= seq_d;
      kind_q    <= kind_d;
      len_low_q <= len_low_d;
      exp_len_q <= exp_len_d;
      crc_q     <= crc_d;
      crc_low_q <= crc_low_d;
      ver_bad_q <= ver_bad_d;
      bank_q    <= bank_d;
    end
  end

endmodule

// ===== hw/rtl/cfp_dq.sv =====
// cfp_dq: two-entry queue of checked-frame descriptors between front and back.
// Depends on cfp_pkg.
module cfp_dq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfp_pkg::desc_t desc_i,
  input  logic           pop_i,
  output cfp_pkg::desc_t head_o,
  output logic           vld_o,
  output logic           full_o
);
  import cfp_pkg::*;

  desc_t      ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o = ent_q[rp_q];
  assign vld_o  = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= desc_i;
  end

endmodule

// ===== hw/rtl/cfp_back.sv =====
// cfp_back: double-banked payload memory and result emitter with output register.
// Depends on cfp_pkg, cfp_out_if.
module cfp_back #(
  parameter int unsigned MAX_PAYLOAD = cfp_pkg::MaxPayloadDef,
  parameter int unsigned MEM_IDX_W   = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfp_pkg::desc_t            head_i,
  input  logic                      head_vld_i,
  output logic                      pop_o,
  input  logic                      wr_en_i,
  input  logic                      wr_bank_i,
  input  logic [MEM_IDX_W-1:0]      wr_addr_i,
  input  logic [cfp_pkg::ByteW-1:0] wr_data_i,
  cfp_out_if.source                 res_o
);
  import cfp_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] seq;
    logic [ByteW-1:0] kind;
    logic [CntW-1:0]  len;
    logic             has_data;
    logic [IdxW-1:0]  idx;
    logic             last;
  } meta_t;

  logic [ByteW-1:0] mem_q [2][MAX_PAYLOAD];
  logic [ByteW-1:0] rdata_q;
  logic [CntW-1:0]  iss_q;
  meta_t            s1_q;
  logic             s1_vld_q;
  meta_t            out_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_vld_q;

  logic [CntW-1:0] n_res;
  logic            iss_last, adv1, issue;

  assign n_res    = (head_i.len == '0) ? CntW'(1) : head_i.len;
  assign iss_last = ((iss_q + 1'b1) == n_res);
  assign adv1     = s1_vld_q && (!out_vld_q || res_o.ready);
  assign issue    = head_vld_i && (!s1_vld_q || adv1);
  assign pop_o    = issue && iss_last;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_bank_i][wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem_q[head_i.bank][iss_q[MEM_IDX_W-1:0]];
      s1_q    <= '{seq: head_i.seq, kind: head_i.kind, len: head_i.len,
                   has_data: (head_i.len != '0), idx: iss_q[IdxW-1:0], last: iss_last};
    end
    if (adv1) begin
      out_q      <= s1_q;
      out_data_q <= s1_q.has_data ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q     <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (issue) iss_q <= iss_last ? '0 : iss_q + 1'b1;
      if (issue) s1_vld_q <= 1'b1;
      else if (adv1) s1_vld_q <= 1'b0;
      if (adv1) out_vld_q <= 1'b1;
      else if (res_o.ready) out_vld_q <= 1'b0;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.seq_num       = out_q.seq;
  assign res_o.frame_kind    = out_q.kind;
  assign res_o.payload_count = out_q.len;
  assign res_o.has_data      = out_q.has_data;
  assign res_o.data_byte     = out_data_q;
  assign res_o.byte_index    = out_q.idx;
  assign res_o.last          = out_q.last;

endmodule

// ===== hw/rtl/crc_checked_frame_parser.sv =====
// crc_checked_frame_parser: one received byte per cycle unless the descriptor queue
// is full; results one per cycle as the sink takes them. A frame's first result
// passes the queue, read stage and output register after its last CRC byte arrives.
// Input stalls only while two checked frames wait for output (two payload banks).
// Reset (async, active low): hunting for sync, registers to defaults, queue empty;
// payload memory is not cleared. Depends on cfp_pkg, cfp_in_if, cfp_out_if.
module crc_checked_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = cfp_pkg::MaxPayloadDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cfp_in_if.sink                       rx_i,
  cfp_out_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfp_pkg::ApbAddrW-1:0] paddr,
  input  logic [cfp_pkg::ApbDataW-1:0] pwdata,
  output logic [cfp_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import cfp_pkg::*;

  localparam int unsigned MemIdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  cfg_t             cfg_q;
  cfg_reg_e         reg_sel;
  logic             cfg_wr;

  logic             q_push, q_pop, q_full, q_vld;
  desc_t            q_in, q_head;
  logic             wr_en, wr_bank;
  logic [MemIdxW-1:0] wr_addr;
  logic [ByteW-1:0] wr_data;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sync_first: SyncFirstRst, sync_second: SyncSecondRst,
                 proto_version: ProtoVerRst};
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SYNC_FIRST:  cfg_q.sync_first    <= pwdata[ByteW-1:0];
        REG_SYNC_SECOND: cfg_q.sync_second   <= pwdata[ByteW-1:0];
        REG_PROTO_VER:   cfg_q.proto_version <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYNC_FIRST:  prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.sync_first};
      REG_SYNC_SECOND: prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.sync_second};
      REG_PROTO_VER:   prdata = {{(ApbDataW-ByteW){1'b0}}, cfg_q.proto_version};
      default:         prdata = '0;
    endcase
  end

  cfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .MEM_IDX_W(MemIdxW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .rx_i      (rx_i),
    .q_full_i  (q_full),
    .push_o    (q_push),
    .desc_o    (q_in),
    .wr_en_o   (wr_en),
    .wr_bank_o (wr_bank),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  cfp_dq u_dq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .desc_i (q_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .vld_o  (q_vld),
    .full_o (q_full)
  );

  cfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .MEM_IDX_W(MemIdxW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .head_vld_i (q_vld),
    .pop_o      (q_pop),
    .wr_en_i    (wr_en),
    .wr_bank_i  (wr_bank),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .res_o      (res_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("descriptor queue overflow");

  a_no_bank_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && q_vld) |-> (q_head.bank != wr_bank))
    else $error("payload write into bank being emitted");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.has_data && res_o.last) |->
      ({1'b0, res_o.byte_index} == (res_o.payload_count - 1'b1)))
    else $error("last result index does not match count");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.has_data) |-> (res_o.last && (res_o.payload_count == '0)))
    else $error("empty frame result malformed");
`endif

endmodule

// ===== dv/cfp_frame_checker.sv =====
// cfp_frame_checker: CRC helper and result type, plus a checker that predicts the
// frame parser's results from the observed byte stream and register writes.
// Depends on cfp_pkg, cfp_in_if, cfp_out_if.
package cfp_check_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [cfp_pkg::ByteW-1:0] seq_num;
    logic [cfp_pkg::ByteW-1:0] frame_kind;
    logic [cfp_pkg::CntW-1:0]  payload_count;
    logic                      has_data;
    logic [cfp_pkg::ByteW-1:0] data_byte;
    logic [cfp_pkg::IdxW-1:0]  byte_index;
    logic                      last;
  } frame_result_t;

  // CRC-16/MODBUS, reflected, one byte
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module cfp_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cfp_in_if                            rx_i,
  cfp_out_if                           res_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [cfp_pkg::ApbAddrW-1:0] paddr,
  input  logic [cfp_pkg::ApbDataW-1:0] pwdata,
  input  logic [cfp_pkg::ApbDataW-1:0] prdata,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           bytes_seen_o,
  output int                           results_seen_o,
  output int                           frames_seen_o
);
  import cfp_pkg::*;
  import cfp_check_pkg::*;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    IN_HEADER,
    IN_BODY
  } parse_phase_e;

  cfg_t            regs;
  parse_phase_e    phase;
  logic [6:0]      pos;
  logic [7:0]      hdr_seq;
  logic [7:0]      hdr_kind;
  logic [7:0]      len_low;
  logic [6:0]      body_len;
  logic [15:0]     crc;
  logic [7:0]      crc_low;
  logic            ver_bad;
  logic [7:0]      payload_mem [MaxPayloadDef];
  frame_result_t   expected_q[$];
  int              mismatches;
  int              n_bytes;
  int              n_results;
  int              n_frames;

  function automatic void restart_hunt();
    phase    = HUNT_FIRST;
    pos      = '0;
    body_len = '0;
    crc      = CrcInit;
    ver_bad  = 1'b0;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Advance the parser by one received byte; queue any frame results it releases.
  function automatic void take_byte(logic [7:0] b);
    logic [15:0]   len16;
    frame_result_t r;
    case (phase)
      HUNT_FIRST: begin
        if (b == regs.sync_first) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == regs.sync_second) begin
          phase   = IN_HEADER;
          pos     = '0;
          crc     = CrcInit;
          ver_bad = 1'b0;
        end else if (b != regs.sync_first) begin
          restart_hunt();
        end
      end
      IN_HEADER: begin
        crc = crc16_modbus_step(crc, b);
        if (pos == 7'd4) begin
          len16 = {b, len_low};
          if (ver_bad || len16 > 16'(MaxPayloadDef)) begin
            restart_hunt();
          end else begin
            body_len = len16[6:0];
            phase    = IN_BODY;
            pos      = '0;
          end
        end else begin
          case (pos)
            7'd0: ver_bad = (b != regs.proto_version);
            7'd1: hdr_seq = b;
            7'd2: hdr_kind = b;
            default: len_low = b;
          endcase
          pos = pos + 7'd1;
        end
      end
      default: begin
        if (pos < body_len) begin
          payload_mem[pos[5:0]] = b;
          crc = crc16_modbus_step(crc, b);
          pos = pos + 7'd1;
        end else if (pos == body_len) begin
          crc_low = b;
          pos = pos + 7'd1;
        end else begin
          if ({b, crc_low} == crc) begin
            r.seq_num    = hdr_seq;
            r.frame_kind = hdr_kind;
            if (body_len == '0) begin
              r.payload_count = '0;
              r.has_data      = 1'b0;
              r.data_byte     = '0;
              r.byte_index    = '0;
              r.last          = 1'b1;
              expected_q.push_back(r);
            end else begin
              for (int i = 0; i < int'(body_len); i++) begin
                r.payload_count = body_len;
                r.has_data      = 1'b1;
                r.data_byte     = payload_mem[i];
                r.byte_index    = IdxW'(i);
                r.last          = (i + 1 == int'(body_len));
                expected_q.push_back(r);
              end
            end
          end
          restart_hunt();
        end
      end
    endcase
  endfunction

  function automatic void check_result();
    frame_result_t w;
    n_results++;
    if (res_i.last) n_frames++;
    if (expected_q.size() == 0) begin
      $error("result transfer with no frame result expected (seq 0x%0h, index %0d)",
             res_i.seq_num, res_i.byte_index);
      mismatches++;
    end else begin
      w = expected_q.pop_front();
      compare_field("seq_num", w.seq_num, res_i.seq_num);
      compare_field("frame_kind", w.frame_kind, res_i.frame_kind);
      compare_field("payload_count", 8'(w.payload_count), 8'(res_i.payload_count));
      compare_field("has_data", 8'(w.has_data), 8'(res_i.has_data));
      compare_field("data_byte", w.data_byte, res_i.data_byte);
      compare_field("byte_index", 8'(w.byte_index), 8'(res_i.byte_index));
      compare_field("last", 8'(w.last), 8'(res_i.last));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      regs       = '{SyncFirstRst, SyncSecondRst, ProtoVerRst};
      hdr_seq    = '0;
      hdr_kind   = '0;
      len_low    = '0;
      crc_low    = '0;
      mismatches = 0;
      n_bytes    = 0;
      n_results  = 0;
      n_frames   = 0;
      expected_q.delete();
      restart_hunt();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (cfg_reg_e'(paddr[ApbAddrW-1:2]))
            REG_SYNC_FIRST:  regs.sync_first = pwdata[7:0];
            REG_SYNC_SECOND: regs.sync_second = pwdata[7:0];
            REG_PROTO_VER:   regs.proto_version = pwdata[7:0];
            default: ;
          endcase
        end else if (cfg_reg_e'(paddr[ApbAddrW-1:2]) != REG_NONE) begin
          case (cfg_reg_e'(paddr[ApbAddrW-1:2]))
            REG_SYNC_FIRST:  want = regs.sync_first;
            REG_SYNC_SECOND: want = regs.sync_second;
            default:         want = regs.proto_version;
          endcase
          compare_field("prdata", want, prdata[7:0]);
        end
      end
      if (rx_i.valid && rx_i.ready) begin
        n_bytes++;
        take_byte(rx_i.rx_byte);
      end
      if (res_i.valid && res_i.ready) check_result();
    end
    fail_count_o   <= mismatches;
    pending_o      <= expected_q.size();
    bytes_seen_o   <= n_bytes;
    results_seen_o <= n_results;
    frames_seen_o  <= n_frames;
  end

endmodule

// ===== dv/crc_checked_frame_parser_test.sv =====
// crc_checked_frame_parser_test: drives framed byte streams, register writes and
// output stalls into the frame parser; cfp_frame_checker predicts and compares.
// Depends on cfp_pkg, cfp_in_if, cfp_out_if, cfp_check_pkg, cfp_frame_checker.
module crc_checked_frame_parser_test;
  import cfp_pkg::*;
  import cfp_check_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int SettleCycles = 16;
  localparam int PhaseBytes   = 107;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int bytes_seen;
  int results_seen;
  int frames_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;

  logic [7:0] sync_first_v;
  logic [7:0] sync_second_v;
  logic [7:0] version_v;
  logic [7:0] frame_q[$];

  cfp_in_if  rx_ch ();
  cfp_out_if res_ch ();

  crc_checked_frame_parser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfp_frame_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_i           (rx_ch),
    .res_i          (res_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .bytes_seen_o   (bytes_seen),
    .results_seen_o (results_seen),
    .frames_seen_o  (frames_seen)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Frame: sync pair, header, payload, little-endian CRC. No payload or CRC for an
  // oversized length. keep >= 0 truncates the frame to that many bytes.
  function automatic void queue_frame(logic [7:0] ver, logic [7:0] seq, logic [7:0] kind,
                                      logic [15:0] len_field, bit bad_crc, int keep);
    logic [15:0] crc;
    logic [7:0]  b;
    int          start;
    start = frame_q.size();
    frame_q.push_back(sync_first_v);
    frame_q.push_back(sync_second_v);
    crc = CrcInit;
    frame_q.push_back(ver);
    frame_q.push_back(seq);
    frame_q.push_back(kind);
    frame_q.push_back(len_field[7:0]);
    frame_q.push_back(len_field[15:8]);
    for (int i = start + 2; i < start + 7; i++) begin
      crc = crc16_modbus_step(crc, frame_q[i]);
    end
    if (len_field <= 16'(MaxPayloadDef)) begin
      for (int i = 0; i < int'(len_field); i++) begin
        b = 8'($urandom);
        frame_q.push_back(b);
        crc = crc16_modbus_step(crc, b);
      end
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
    end
    if (keep >= 0) begin
      while (frame_q.size() > start + keep) void'(frame_q.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_queued();
    while (frame_q.size() > 0) send_byte(frame_q.pop_front());
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input cfg_reg_e r, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ApbAddrW'({r, 2'b00});
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] sf, input logic [7:0] ss, input logic [7:0] ver);
    apb_access(1'b1, REG_SYNC_FIRST, sf);
    apb_access(1'b1, REG_SYNC_SECOND, ss);
    apb_access(1'b1, REG_PROTO_VER, ver);
    apb_access(1'b1, REG_NONE, 8'($urandom));
    apb_access(1'b0, REG_SYNC_FIRST, 8'h00);
    apb_access(1'b0, REG_SYNC_SECOND, 8'h00);
    apb_access(1'b0, REG_PROTO_VER, 8'h00);
    sync_first_v  = sf;
    sync_second_v = ss;
    version_v     = ver;
  endtask

  // Mostly good frames; the rest bad CRC, wrong version, oversized length,
  // truncated frames, line noise and repeated first sync bytes.
  task automatic random_traffic(input int n_bytes);
    int          sent;
    int          pick;
    int          len;
    logic [15:0] len16;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(9, MaxPayloadDef) : $urandom_range(8);
      if ($urandom_range(29) == 0) len = MaxPayloadDef;
      if (pick < 55) begin
        queue_frame(version_v, 8'($urandom), 8'($urandom), 16'(len), 1'b0, -1);
      end else if (pick < 65) begin
        queue_frame(version_v, 8'($urandom), 8'($urandom), 16'(len), 1'b1, -1);
      end else if (pick < 73) begin
        queue_frame(version_v ^ 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                    16'(len), 1'b0, -1);
      end else if (pick < 80) begin
        len16 = $urandom_range(1) ? {8'($urandom_range(1, 255)), 8'($urandom)}
                                  : 16'($urandom_range(MaxPayloadDef + 1, 255));
        queue_frame(version_v, 8'($urandom), 8'($urandom), len16, 1'b0, -1);
      end else if (pick < 88) begin
        queue_frame(version_v, 8'($urandom), 8'($urandom), 16'(len), 1'b0,
                    $urandom_range(1, len + 8));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(sync_first_v);
        queue_frame(version_v, 8'($urandom), 8'($urandom), 16'(len), 1'b0, -1);
      end
      sent += frame_q.size();
      send_queued();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sync_first_v   = SyncFirstRst;
    sync_second_v  = SyncSecondRst;
    version_v      = ProtoVerRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, no idling: repeated first sync then an empty frame,
    // a wrong version and a length just over the maximum.
    frame_q.push_back(sync_first_v);
    queue_frame(version_v, 8'hFF, 8'h00, 16'd0, 1'b0, -1);
    queue_frame(8'h00, 8'h00, 8'hFF, 16'd0, 1'b0, 7);
    queue_frame(version_v, 8'h5A, 8'hA5, 16'(MaxPayloadDef + 1), 1'b0, -1);
    send_queued();
    random_traffic(PhaseBytes);
    drain();

    configure(8'h00, 8'hFF, 8'hFF);
    send_idle_pct = 79;
    random_traffic(PhaseBytes);
    drain();

    configure(8'hFF, 8'h00, 8'h00);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    random_traffic(PhaseBytes);
    drain();

    configure(8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    random_traffic(PhaseBytes);
    drain();

    $display("Fed %0d bytes under four register settings and idle patterns;", bytes_seen);
    $display("checked %0d result transfers from %0d emitted frames.", results_seen,
             frames_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_in_if.sv
hw/rtl/cfp_out_if.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_dq.sv
hw/rtl/cfp_back.sv
hw/rtl/crc_checked_frame_parser.sv
dv/cfp_frame_checker.sv
dv/crc_checked_frame_parser_test.sv
